### rtl/tmp_pkg.sv
package tmp_pkg;

   localparam int PC_BITS = 6;

   localparam logic [1:0] CSR_GOAL     = 2'd0;
   localparam logic [1:0] CSR_ACCEL    = 2'd1;
   localparam logic [1:0] CSR_VELOCITY = 2'd2;

   localparam logic [31:0] GOAL_RESET     = 32'h0000_0000;
   localparam logic [31:0] ACCEL_RESET    = 32'h0001_0000;
   localparam logic [31:0] VELOCITY_RESET = 32'h0001_0000;

   localparam logic CMD_PLAN   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   // microprogram entry points
   localparam logic [PC_BITS-1:0] PC_PLAN   = 6'd0;
   localparam logic [PC_BITS-1:0] PC_ACCEL  = 6'd7;
   localparam logic [PC_BITS-1:0] PC_CRUISE = 6'd11;
   localparam logic [PC_BITS-1:0] PC_DECEL  = 6'd17;
   localparam logic [PC_BITS-1:0] PC_DONE   = 6'd31;
   localparam logic [PC_BITS-1:0] PC_LAST   = 6'd39;

   typedef struct packed {
      logic               cmd;
      logic signed [31:0] sample_time;
   } req_type;

   typedef struct packed {
      logic signed [31:0] position;
      logic signed [31:0] velocity;
      logic signed [31:0] acceleration;
      logic [30:0]        final_time;
      logic               triangular;
   } rsp_type;

   typedef enum logic [2:0] {
      ALU_ADD, ALU_SUB, ALU_HALF, ALU_MUL, ALU_DIV, ALU_SQRT
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_ctrl_type;

   typedef enum logic [3:0] {
      SRC_ZERO, SRC_TIME, SRC_GOAL, SRC_ACCEL, SRC_PEAK, SRC_RAMP, SRC_CRUISE,
      SRC_MOVE, SRC_X0, SRC_X1, SRC_X2, SRC_VEL, SRC_ACC
   } src_type;

   typedef enum logic [3:0] {
      DST_RAMP, DST_CRUISE, DST_MOVE, DST_PEAK, DST_RAMP_CRUISE, DST_X0, DST_X1,
      DST_X2, DST_POS, DST_VEL, DST_ACC
   } dst_type;

   typedef struct packed {
      alu_op_type op;
      src_type    src_a;
      src_type    src_b;
      dst_type    dst;
      logic       chk;
      logic       last;
   } uop_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DISPATCH, ST_ISSUE, ST_WAIT, ST_FINISH
   } seq_state_type;

   function automatic uop_type uop_rom(input logic [PC_BITS-1:0] pc);
      uop_type u;
      unique case (pc)
         // plan
         6'd0:  u = '{ALU_DIV,  SRC_PEAK,   SRC_ACCEL,  DST_RAMP,        1'b0, 1'b0};
         6'd1:  u = '{ALU_DIV,  SRC_GOAL,   SRC_PEAK,   DST_CRUISE,      1'b0, 1'b0};
         6'd2:  u = '{ALU_ADD,  SRC_RAMP,   SRC_CRUISE, DST_MOVE,        1'b1, 1'b0};
         6'd3:  u = '{ALU_DIV,  SRC_GOAL,   SRC_ACCEL,  DST_X0,          1'b0, 1'b0};
         6'd4:  u = '{ALU_SQRT, SRC_X0,     SRC_ZERO,   DST_RAMP_CRUISE, 1'b0, 1'b0};
         6'd5:  u = '{ALU_ADD,  SRC_RAMP,   SRC_RAMP,   DST_MOVE,        1'b0, 1'b0};
         6'd6:  u = '{ALU_MUL,  SRC_ACCEL,  SRC_RAMP,   DST_PEAK,        1'b0, 1'b1};
         // accelerating
         6'd7:  u = '{ALU_ADD,  SRC_ACCEL,  SRC_ZERO,   DST_ACC,         1'b0, 1'b0};
         6'd8:  u = '{ALU_MUL,  SRC_ACCEL,  SRC_TIME,   DST_VEL,         1'b0, 1'b0};
         6'd9:  u = '{ALU_MUL,  SRC_VEL,    SRC_TIME,   DST_X0,          1'b0, 1'b0};
         6'd10: u = '{ALU_HALF, SRC_X0,     SRC_ZERO,   DST_POS,         1'b0, 1'b1};
         // cruising
         6'd11: u = '{ALU_MUL,  SRC_ACCEL,  SRC_RAMP,   DST_VEL,         1'b0, 1'b0};
         6'd12: u = '{ALU_MUL,  SRC_PEAK,   SRC_RAMP,   DST_X0,          1'b0, 1'b0};
         6'd13: u = '{ALU_HALF, SRC_X0,     SRC_ZERO,   DST_X0,          1'b0, 1'b0};
         6'd14: u = '{ALU_SUB,  SRC_TIME,   SRC_RAMP,   DST_X1,          1'b0, 1'b0};
         6'd15: u = '{ALU_MUL,  SRC_VEL,    SRC_X1,     DST_X1,          1'b0, 1'b0};
         6'd16: u = '{ALU_ADD,  SRC_X0,     SRC_X1,     DST_POS,         1'b0, 1'b1};
         // decelerating
         6'd17: u = '{ALU_SUB,  SRC_TIME,   SRC_CRUISE, DST_X2,          1'b0, 1'b0};
         6'd18: u = '{ALU_SUB,  SRC_ZERO,   SRC_ACCEL,  DST_ACC,         1'b0, 1'b0};
         6'd19: u = '{ALU_MUL,  SRC_ACCEL,  SRC_RAMP,   DST_X0,          1'b0, 1'b0};
         6'd20: u = '{ALU_MUL,  SRC_ACC,    SRC_X2,     DST_X1,          1'b0, 1'b0};
         6'd21: u = '{ALU_ADD,  SRC_X0,     SRC_X1,     DST_VEL,         1'b0, 1'b0};
         6'd22: u = '{ALU_MUL,  SRC_PEAK,   SRC_RAMP,   DST_X0,          1'b0, 1'b0};
         6'd23: u = '{ALU_HALF, SRC_X0,     SRC_ZERO,   DST_X0,          1'b0, 1'b0};
         6'd24: u = '{ALU_SUB,  SRC_CRUISE, SRC_RAMP,   DST_X1,          1'b0, 1'b0};
         6'd25: u = '{ALU_MUL,  SRC_PEAK,   SRC_X1,     DST_X1,          1'b0, 1'b0};
         6'd26: u = '{ALU_ADD,  SRC_X0,     SRC_X1,     DST_X0,          1'b0, 1'b0};
         6'd27: u = '{ALU_ADD,  SRC_PEAK,   SRC_VEL,    DST_X1,          1'b0, 1'b0};
         6'd28: u = '{ALU_MUL,  SRC_X1,     SRC_X2,     DST_X1,          1'b0, 1'b0};
         6'd29: u = '{ALU_HALF, SRC_X1,     SRC_ZERO,   DST_X1,          1'b0, 1'b0};
         6'd30: u = '{ALU_ADD,  SRC_X0,     SRC_X1,     DST_POS,         1'b0, 1'b1};
         // move reached
         6'd31: u = '{ALU_MUL,  SRC_PEAK,   SRC_RAMP,   DST_X0,          1'b0, 1'b0};
         6'd32: u = '{ALU_HALF, SRC_X0,     SRC_ZERO,   DST_X0,          1'b0, 1'b0};
         6'd33: u = '{ALU_SUB,  SRC_CRUISE, SRC_RAMP,   DST_X1,          1'b0, 1'b0};
         6'd34: u = '{ALU_MUL,  SRC_PEAK,   SRC_X1,     DST_X1,          1'b0, 1'b0};
         6'd35: u = '{ALU_ADD,  SRC_X0,     SRC_X1,     DST_X0,          1'b0, 1'b0};
         6'd36: u = '{ALU_SUB,  SRC_MOVE,   SRC_CRUISE, DST_X1,          1'b0, 1'b0};
         6'd37: u = '{ALU_MUL,  SRC_PEAK,   SRC_X1,     DST_X1,          1'b0, 1'b0};
         6'd38: u = '{ALU_HALF, SRC_X1,     SRC_ZERO,   DST_X1,          1'b0, 1'b0};
         6'd39: u = '{ALU_ADD,  SRC_X0,     SRC_X1,     DST_POS,         1'b0, 1'b1};
         default: u = '{ALU_ADD, SRC_ZERO,  SRC_ZERO,   DST_X0,          1'b0, 1'b1};
      endcase
      return u;
   endfunction

endpackage

### rtl/trapezoid_motion_profile_unit.sv
// channel  direction  handshake             payload
// req      in         req_valid/req_stall   tmp_pkg::req_type (cmd, sample_time)
// rsp      out        rsp_valid/rsp_stall   tmp_pkg::rsp_type (position .. triangular)
// csr      in         csr_wr_en             csr_index, csr_wdata
// one beat at a time: every step runs on a single shared add/multiply/divide/sqrt unit
// multiply, divide and square root run as iterative shift loops; add, subtract and halve do not
// plan: two divides and an add, then one more divide, a root and a multiply if triangular, at Q16.16
// sample: 0 to 14 steps, the most in the deceleration segment
// synchronous reset loads the default limits and the all-zero plan, no clearing pass
// a finished result waits in the output register while the next beat is taken
module trapezoid_motion_profile_unit #(
   parameter int FRAC_BITS = 16,
   parameter int WORD_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tmp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tmp_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_wdata
);
   import tmp_pkg::*;

   localparam int W  = WORD_BITS;
   localparam int EW = (W > 32) ? W : 32;
   localparam logic signed [EW-1:0] E_MAX = EW'({1'b0, {(W-1){1'b1}}});
   localparam logic signed [EW-1:0] E_MIN = -E_MAX - 1;
   localparam logic [W-1:0] MAX_W = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MIN_W = {1'b1, {(W-1){1'b0}}};

   seq_state_type state_ff, state_in;
   logic [PC_BITS-1:0] pc_ff, pc_in;
   logic [31:0] goal_cfg_ff, accel_cfg_ff, vel_cfg_ff;
   logic cmd_ff;
   logic signed [W-1:0] time_ff, ramp_ff, cruise_ff, move_ff, accel_ff, peak_ff;
   logic signed [W-1:0] x0_ff, x1_ff, x2_ff, pos_ff, vel_ff, acc_ff;
   logic bb_ff;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   alu_ctrl_type alu_ctrl;
   logic signed [W-1:0] alu_a, alu_b, alu_result;
   logic alu_done;
   uop_type uop;
   logic accept, out_free, writeback, bb_now;
   logic signed [W-1:0] goal_w, accel_w, vel_w, accel_fix, vel_fix;
   logic [31:0] move_word;

   function automatic logic signed [W-1:0] from32(input logic [31:0] v);
      logic signed [EW-1:0] e;
      e = EW'($signed(v));
      if (e > E_MAX) e = E_MAX;
      else if (e < E_MIN) e = E_MIN;
      return e[W-1:0];
   endfunction

   function automatic logic [31:0] to32(input logic signed [W-1:0] v);
      logic signed [EW-1:0] e;
      e = EW'(v);
      return e[31:0];
   endfunction

   // limits take the sign of the goal
   function automatic logic signed [W-1:0] fix_sign(input logic signed [W-1:0] v,
                                                    input logic goal_neg);
      logic signed [W-1:0] r;
      r = v;
      if (goal_neg) begin
         if (v > 0) r = -v;
      end else if (v < 0) begin
         r = (v == MIN_W) ? MAX_W : -v;
      end
      return r;
   endfunction

   function automatic logic signed [W-1:0] pick(input src_type s, input logic signed [W-1:0]
                                                t, g, a, p, r, c, m, x0, x1, x2, vl, ac);
      logic signed [W-1:0] o;
      unique case (s)
         SRC_ZERO:   o = '0;
         SRC_TIME:   o = t;
         SRC_GOAL:   o = g;
         SRC_ACCEL:  o = a;
         SRC_PEAK:   o = p;
         SRC_RAMP:   o = r;
         SRC_CRUISE: o = c;
         SRC_MOVE:   o = m;
         SRC_X0:     o = x0;
         SRC_X1:     o = x1;
         SRC_X2:     o = x2;
         SRC_VEL:    o = vl;
         SRC_ACC:    o = ac;
         default:    o = '0;
      endcase
      return o;
   endfunction

   assign goal_w    = from32(goal_cfg_ff);
   assign accel_w   = from32(accel_cfg_ff);
   assign vel_w     = from32(vel_cfg_ff);
   assign accel_fix = fix_sign(accel_w, goal_w[W-1]);
   assign vel_fix   = fix_sign(vel_w, goal_w[W-1]);
   assign move_word = to32(move_ff);
   assign uop       = uop_rom(pc_ff);
   assign bb_now    = ramp_ff >= cruise_ff;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign alu_a     = pick(uop.src_a, time_ff, goal_w, accel_ff, peak_ff, ramp_ff, cruise_ff,
                           move_ff, x0_ff, x1_ff, x2_ff, vel_ff, acc_ff);
   assign alu_b     = pick(uop.src_b, time_ff, goal_w, accel_ff, peak_ff, ramp_ff, cruise_ff,
                           move_ff, x0_ff, x1_ff, x2_ff, vel_ff, acc_ff);

   tmp_alu #(.W(W), .F(FRAC_BITS)) u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (alu_ctrl),
      .op_a   (alu_a),
      .op_b   (alu_b),
      .done   (alu_done),
      .result (alu_result)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            state_in = ST_ISSUE;
            if (cmd_ff == CMD_PLAN) pc_in = PC_PLAN;
            else if (time_ff < 0) state_in = ST_FINISH;
            else if (time_ff <= ramp_ff) pc_in = PC_ACCEL;
            else if (time_ff <= cruise_ff) pc_in = PC_CRUISE;
            else if (time_ff <= move_ff) pc_in = PC_DECEL;
            else pc_in = PC_DONE;
         end
         ST_ISSUE: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (alu_done) begin
               if (uop.last || (uop.chk && !bb_now)) begin
                  state_in = ST_FINISH;
               end else begin
                  pc_in    = pc_ff + 1'b1;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_stall      = 1'b1;
      alu_ctrl.start = 1'b0;
      alu_ctrl.op    = uop.op;
      writeback      = 1'b0;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE:     req_stall = 1'b0;
         ST_DISPATCH: req_stall = 1'b1;
         ST_ISSUE:    alu_ctrl.start = 1'b1;
         ST_WAIT:     writeback = alu_done;
         ST_FINISH:   if (out_free) rsp_valid_in = 1'b1;
         default:     req_stall = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         goal_cfg_ff  <= GOAL_RESET;
         accel_cfg_ff <= ACCEL_RESET;
         vel_cfg_ff   <= VELOCITY_RESET;
         ramp_ff      <= '0;
         cruise_ff    <= '0;
         move_ff      <= '0;
         accel_ff     <= '0;
         peak_ff      <= '0;
         bb_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_GOAL:     goal_cfg_ff  <= csr_wdata;
               CSR_ACCEL:    accel_cfg_ff <= csr_wdata;
               CSR_VELOCITY: vel_cfg_ff   <= csr_wdata;
               default:      goal_cfg_ff  <= goal_cfg_ff;
            endcase
         end
         if (accept && req_data.cmd == CMD_PLAN) begin
            accel_ff <= accel_fix;
            peak_ff  <= vel_fix;
         end
         if (writeback) begin
            unique case (uop.dst)
               DST_RAMP:   ramp_ff   <= alu_result;
               DST_CRUISE: cruise_ff <= alu_result;
               DST_MOVE:   move_ff   <= alu_result;
               DST_PEAK:   peak_ff   <= alu_result;
               DST_RAMP_CRUISE: begin
                  ramp_ff   <= alu_result;
                  cruise_ff <= alu_result;
               end
               default: ramp_ff <= ramp_ff;
            endcase
            if (uop.chk) bb_ff <= bb_now;
         end
      end
      if (accept) begin
         cmd_ff  <= req_data.cmd;
         time_ff <= from32(req_data.sample_time);
         pos_ff  <= '0;
         vel_ff  <= '0;
         acc_ff  <= '0;
      end
      if (writeback) begin
         unique case (uop.dst)
            DST_X0:  x0_ff  <= alu_result;
            DST_X1:  x1_ff  <= alu_result;
            DST_X2:  x2_ff  <= alu_result;
            DST_POS: pos_ff <= alu_result;
            DST_VEL: vel_ff <= alu_result;
            DST_ACC: acc_ff <= alu_result;
            default: x0_ff  <= x0_ff;
         endcase
      end
      if (state_ff == ST_FINISH && out_free) begin
         rsp_data_ff.position     <= to32(pos_ff);
         rsp_data_ff.velocity     <= to32(vel_ff);
         rsp_data_ff.acceleration <= to32(acc_ff);
         rsp_data_ff.final_time   <= move_word[30:0];
         rsp_data_ff.triangular   <= bb_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_single_issue: assert property (@(posedge clock) disable iff (reset)
      alu_ctrl.start |=> !alu_ctrl.start)
      else $error("shared unit started twice in a row");
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      alu_done |-> state_ff == ST_WAIT)
      else $error("unit result arrived outside wait");
   a_finish_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && out_free) |=> rsp_valid_ff)
      else $error("finished beat not presented");
   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ISSUE |-> pc_ff <= PC_LAST)
      else $error("microprogram counter out of range");
`endif

endmodule

### rtl/tmp_alu.sv
module tmp_alu #(
   parameter int W = 32,
   parameter int F = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tmp_pkg::alu_ctrl_type ctrl,
   input  logic signed [W-1:0]   op_a,
   input  logic signed [W-1:0]   op_b,
   output logic                  done,
   output logic signed [W-1:0]   result
);
   import tmp_pkg::*;

   localparam int PW = 2 * W;
   localparam int DW = W + F;
   localparam int K  = (W + F + 1) / 2;
   localparam int SW = 2 * K;
   localparam int CW = $clog2(DW + 1);
   localparam logic [W-1:0] MAX_W = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MIN_W = {1'b1, {(W-1){1'b0}}};

   logic              busy_ff, busy_in, done_ff, done_in, neg_ff, neg_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   alu_op_type        op_ff, op_in;
   logic [W-1:0]      result_ff, result_in;
   logic [W-1:0]      mcand_ff, mcand_in, mplier_ff, mplier_in;
   logic [PW-1:0]     acc_ff, acc_in;
   logic [DW-1:0]     dvd_ff, dvd_in, quo_ff, quo_in;
   logic [W-1:0]      dvs_ff, dvs_in, rem_ff, rem_in;
   logic [SW-1:0]     sq_ff, sq_in;
   logic [K+1:0]      srem_ff, srem_in;
   logic [K-1:0]      root_ff, root_in;

   logic [W:0]        sum, r2;
   logic [K+3:0]      rem2, trial;
   logic [PW-1:0]     prod_q;
   logic [W-1:0]      lim, q;

   function automatic logic [W-1:0] mag(input logic [W-1:0] v);
      return v[W-1] ? W'(-v) : v;
   endfunction

   function automatic logic [W-1:0] sat(input logic [W:0] s);
      return (s[W] != s[W-1]) ? (s[W] ? MIN_W : MAX_W) : s[W-1:0];
   endfunction

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      neg_in    = neg_ff;
      cnt_in    = cnt_ff;
      op_in     = op_ff;
      result_in = result_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      dvd_in    = dvd_ff;
      quo_in    = quo_ff;
      dvs_in    = dvs_ff;
      rem_in    = rem_ff;
      sq_in     = sq_ff;
      srem_in   = srem_ff;
      root_in   = root_ff;
      sum       = '0;
      r2        = {rem_ff, dvd_ff[DW-1]};
      rem2      = {srem_ff, sq_ff[SW-1:SW-2]};
      trial     = (K+4)'({root_ff, 2'b01});
      prod_q    = acc_ff >> F;
      lim       = neg_ff ? MIN_W : MAX_W;
      q         = '0;
      if (ctrl.start) begin
         op_in  = ctrl.op;
         neg_in = op_a[W-1] ^ op_b[W-1];
         unique case (ctrl.op)
            ALU_ADD: begin
               sum       = {op_a[W-1], op_a} + {op_b[W-1], op_b};
               result_in = sat(sum);
               done_in   = 1'b1;
            end
            ALU_SUB: begin
               sum       = {op_a[W-1], op_a} - {op_b[W-1], op_b};
               result_in = sat(sum);
               done_in   = 1'b1;
            end
            ALU_HALF: begin
               // rounds toward zero
               sum       = {op_a[W-1], op_a} + (W+1)'(op_a[W-1]);
               result_in = sum[W:1];
               done_in   = 1'b1;
            end
            ALU_MUL: begin
               mcand_in  = mag(op_a);
               mplier_in = mag(op_b);
               acc_in    = '0;
               cnt_in    = CW'(W);
               busy_in   = 1'b1;
            end
            ALU_DIV: begin
               if (op_b == '0) begin
                  result_in = MAX_W;
                  done_in   = 1'b1;
               end else begin
                  dvd_in  = {mag(op_a), {F{1'b0}}};
                  dvs_in  = mag(op_b);
                  rem_in  = '0;
                  quo_in  = '0;
                  cnt_in  = CW'(DW);
                  busy_in = 1'b1;
               end
            end
            ALU_SQRT: begin
               if (op_a[W-1] || op_a == '0) begin
                  result_in = '0;
                  done_in   = 1'b1;
               end else begin
                  sq_in   = SW'(op_a) << F;
                  srem_in = '0;
                  root_in = '0;
                  cnt_in  = CW'(K);
                  busy_in = 1'b1;
               end
            end
            default: begin
               done_in = 1'b1;
            end
         endcase
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            cnt_in = cnt_ff - 1'b1;
            unique case (op_ff)
               ALU_MUL: begin
                  acc_in    = (acc_ff << 1) + (mplier_ff[W-1] ? PW'(mcand_ff) : '0);
                  mplier_in = mplier_ff << 1;
               end
               ALU_DIV: begin
                  if (r2 >= {1'b0, dvs_ff}) begin
                     rem_in = W'(r2 - {1'b0, dvs_ff});
                     quo_in = {quo_ff[DW-2:0], 1'b1};
                  end else begin
                     rem_in = W'(r2);
                     quo_in = {quo_ff[DW-2:0], 1'b0};
                  end
                  dvd_in = dvd_ff << 1;
               end
               ALU_SQRT: begin
                  if (rem2 >= trial) begin
                     srem_in = (K+2)'(rem2 - trial);
                     root_in = {root_ff[K-2:0], 1'b1};
                  end else begin
                     srem_in = (K+2)'(rem2);
                     root_in = {root_ff[K-2:0], 1'b0};
                  end
                  sq_in = sq_ff << 2;
               end
               default: begin
                  cnt_in = '0;
               end
            endcase
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
            unique case (op_ff)
               ALU_MUL: begin
                  q         = (prod_q > PW'(lim)) ? lim : prod_q[W-1:0];
                  result_in = neg_ff ? W'(-q) : q;
               end
               ALU_DIV: begin
                  // quotient bits at or above the sign position overflow
                  q         = (|quo_ff[DW-1:W-1]) ? lim : {1'b0, quo_ff[W-2:0]};
                  result_in = neg_ff ? W'(-q) : q;
               end
               ALU_SQRT: begin
                  result_in = (W'(root_ff) > MAX_W) ? MAX_W : W'(root_ff);
               end
               default: begin
                  result_in = result_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         op_ff   <= ALU_ADD;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         op_ff   <= op_in;
      end
      neg_ff    <= neg_in;
      result_ff <= result_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      dvd_ff    <= dvd_in;
      quo_ff    <= quo_in;
      dvs_ff    <= dvs_in;
      rem_ff    <= rem_in;
      sq_ff     <= sq_in;
      srem_ff   <= srem_in;
      root_ff   <= root_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule
